/* rtl/vad_pkg.sv */
package vad_pkg;

    // Field and datapath widths.
    localparam int QW   = 16;   // quantized position and octahedral inputs
    localparam int PW   = 17;   // Q1.16 position
    localparam int NW   = 16;   // Q1.14 normal component
    localparam int MW   = 16;   // magnitude of a folded normal component
    localparam int SQW  = 32;   // square of one magnitude
    localparam int SW   = 34;   // sum of three squares
    localparam int LW   = 50;   // running product of candidate and length squared
    localparam int DW   = 68;   // signed remainder of the root search
    localparam int RW   = 15;   // bits of one normalized magnitude
    localparam int NSTG = 15;   // root search stages, one result bit each
    localparam int BW   = 4;    // width of a stage's bit position
    localparam int CW   = 32;   // packed RGBA8 color
    localparam int FW   = 32;   // feature identifier

    // Octahedral scale and the rhs shift that stands for 32768 squared.
    localparam logic [MW-1:0] OCT_D     = 16'hFFFF;
    localparam int            RHS_SHIFT = 30;
    localparam logic [NW-1:0] NORM_ONE  = 16'h4000;

    // Configuration register indexes.
    localparam logic [0:0] CFG_DEFAULT_COLOR = 1'b0;
    localparam logic [0:0] CFG_ALPHA_MODE    = 1'b1;
    localparam logic [CW-1:0] DEFAULT_COLOR_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [QW-1:0] qpos_x;
        logic [QW-1:0] qpos_y;
        logic [QW-1:0] qpos_z;
        logic          has_position;
        logic [QW-1:0] oct_u;
        logic [QW-1:0] oct_v;
        logic          has_normal;
        logic [CW-1:0] packed_color;
        logic          has_color;
        logic [FW-1:0] feature_in;
        logic          has_feature;
    } t_vtx_in;

    typedef struct packed {
        logic [PW-1:0]        pos_x;
        logic [PW-1:0]        pos_y;
        logic [PW-1:0]        pos_z;
        logic signed [NW-1:0] norm_x;
        logic signed [NW-1:0] norm_y;
        logic signed [NW-1:0] norm_z;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [7:0]           alpha;
        logic [FW-1:0]        feature_out;
    } t_vtx_out;

    // Everything that rides along beside the normal search.
    typedef struct packed {
        logic          has_normal;
        logic [2:0]    neg;
        logic [PW-1:0] pos_x;
        logic [PW-1:0] pos_y;
        logic [PW-1:0] pos_z;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [7:0]    alpha;
        logic [FW-1:0] feature_out;
    } t_side;

    // State of the bit-serial root search for the three components.
    typedef struct packed {
        logic [SW-1:0]                s;
        logic [2:0][DW-1:0]           d;
        logic [2:0][LW-1:0]           l;
        logic [2:0][RW-1:0]           n;
    } t_root;

endpackage

/* rtl/vad_front.sv */
module vad_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  vad_pkg::t_vtx_in  i_vtx,
    input  logic [31:0]       i_def_color,
    input  logic              i_alpha_mode,
    output logic              o_valid,
    output vad_pkg::t_side    o_side,
    output vad_pkg::t_root    o_root
);

    logic                             r_vld1, r_vld2, r_vld3;
    logic [2:0][vad_pkg::MW-1:0]      r_mag1;
    logic [2:0][vad_pkg::SQW-1:0]     r_sq2;
    vad_pkg::t_side                   r_side1, r_side2, r_side3;
    vad_pkg::t_root                   r_root3;

    logic signed [18:0]               n_a, n_b;
    logic [vad_pkg::MW-1:0]           n_ma, n_mb;
    logic signed [17:0]               n_c;
    logic [2:0][vad_pkg::MW-1:0]      n_mag;
    logic [2:0]                       n_neg;
    logic [vad_pkg::CW-1:0]           n_col;
    vad_pkg::t_side                   n_side;
    vad_pkg::t_root                   n_root;

    // Octahedral unfold: map to odd values in -D..D and fold the lower half.
    always_comb begin
        n_a  = $signed({2'b00, i_vtx.oct_u, 1'b0}) - $signed({3'b000, vad_pkg::OCT_D});
        n_b  = $signed({2'b00, i_vtx.oct_v, 1'b0}) - $signed({3'b000, vad_pkg::OCT_D});
        n_ma = n_a[18] ? vad_pkg::MW'(-n_a) : vad_pkg::MW'(n_a);
        n_mb = n_b[18] ? vad_pkg::MW'(-n_b) : vad_pkg::MW'(n_b);
        n_c  = $signed({2'b00, vad_pkg::OCT_D}) - $signed({2'b00, n_ma})
             - $signed({2'b00, n_mb});
        if (n_c[17]) begin
            n_mag[0] = vad_pkg::OCT_D - n_mb;
            n_mag[1] = vad_pkg::OCT_D - n_ma;
        end else begin
            n_mag[0] = n_ma;
            n_mag[1] = n_mb;
        end
        n_mag[2] = n_c[17] ? vad_pkg::MW'(-n_c) : vad_pkg::MW'(n_c);
        n_neg    = {n_c[17], n_b[18], n_a[18]};
    end

    // Position scale by 65536/65535 rounds to q plus its top bit; color and id.
    always_comb begin
        n_side.has_normal = i_vtx.has_normal;
        n_side.neg        = n_neg;
        n_side.pos_x = i_vtx.has_position ?
            {1'b0, i_vtx.qpos_x} + vad_pkg::PW'(i_vtx.qpos_x[15]) : '0;
        n_side.pos_y = i_vtx.has_position ?
            {1'b0, i_vtx.qpos_y} + vad_pkg::PW'(i_vtx.qpos_y[15]) : '0;
        n_side.pos_z = i_vtx.has_position ?
            {1'b0, i_vtx.qpos_z} + vad_pkg::PW'(i_vtx.qpos_z[15]) : '0;
        n_col        = i_vtx.has_color ? i_vtx.packed_color : i_def_color;
        n_side.red   = n_col[7:0];
        n_side.green = n_col[15:8];
        n_side.blue  = n_col[23:16];
        n_side.alpha = (i_vtx.has_color && i_alpha_mode) ? 8'hFF - n_col[31:24]
                                                         : n_col[31:24];
        n_side.feature_out = i_vtx.has_feature ? i_vtx.feature_in : '0;
    end

    // Search start: length squared, scaled squares as remainders, empty result.
    always_comb begin
        n_root.s = vad_pkg::SW'(r_sq2[0]) + vad_pkg::SW'(r_sq2[1])
                 + vad_pkg::SW'(r_sq2[2]);
        for (int j = 0; j < 3; j++) begin
            n_root.d[j] = vad_pkg::DW'({r_sq2[j], {vad_pkg::RHS_SHIFT{1'b0}}});
            n_root.l[j] = '0;
            n_root.n[j] = '0;
        end
    end

    // Valid bits of the three front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Payload of the three front stages, with squaring in the middle one.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag1  <= n_mag;
            r_side1 <= n_side;
            for (int j = 0; j < 3; j++) begin
                r_sq2[j] <= r_mag1[j] * r_mag1[j];
            end
            r_side2 <= r_side1;
            r_root3 <= n_root;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_vld3;
    assign o_side  = r_side3;
    assign o_root  = r_root3;

endmodule

/* rtl/vad_root_stage.sv */
module vad_root_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [vad_pkg::BW-1:0] i_bit,
    input  logic                   i_valid,
    input  vad_pkg::t_root         i_root,
    input  vad_pkg::t_side         i_side,
    output logic                   o_valid,
    output vad_pkg::t_root         o_root,
    output vad_pkg::t_side         o_side
);

    logic                          r_vld;
    vad_pkg::t_root                r_root;
    vad_pkg::t_side                r_side;

    logic [5:0]                    n_sh1, n_sh2, n_sh4;
    logic [vad_pkg::DW-1:0]        n_sx, n_lx, n_term;
    vad_pkg::t_root                n_root;

    // Shift amounts for the tested bit k: k+1, k+2 and 2k+2.
    always_comb begin
        n_sh1 = {2'b00, i_bit} + 6'd1;
        n_sh2 = {2'b00, i_bit} + 6'd2;
        n_sh4 = {1'b0, i_bit, 1'b0} + 6'd2;
    end

    // Try setting bit k: (w + 2^(k+1) - 1)^2 * s must not exceed the rhs.
    always_comb begin
        n_sx   = vad_pkg::DW'(i_root.s);
        n_root = i_root;
        n_lx   = '0;
        n_term = '0;
        for (int j = 0; j < 3; j++) begin
            n_lx   = vad_pkg::DW'(i_root.l[j]);
            n_term = (n_lx << n_sh2) - (n_lx << 1) + (n_sx << n_sh4)
                   - (n_sx << n_sh2) + n_sx;
            if ($signed(n_term) <= $signed(i_root.d[j])) begin
                n_root.d[j] = i_root.d[j] - (n_lx << n_sh2) - (n_sx << n_sh4);
                n_root.l[j] = vad_pkg::LW'(n_lx + (n_sx << n_sh1));
                n_root.n[j] = i_root.n[j] | (vad_pkg::RW'(1) << i_bit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_vld;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

/* rtl/vertex_attribute_decode_top.sv */
// Pipeline: 3 decode and squaring stages (the first loaded at the edge that accepts
// a request), 15 root search stages at one result bit each, 1 output stage.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output, and input stall follows that output stall.
// Reset (synchronous, active low) clears all valid bits, the default color to
// opaque white and the alpha mode to off.
module vertex_attribute_decode_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vad_pkg::t_vtx_in   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output vad_pkg::t_vtx_out  o_data,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    logic [vad_pkg::CW-1:0]   r_def_color;
    logic                     r_alpha_mode;
    logic                     r_out_vld;
    vad_pkg::t_vtx_out        r_out;

    logic                     n_adv;
    logic [vad_pkg::NSTG:0]   stg_vld;
    vad_pkg::t_root           stg_root [0:vad_pkg::NSTG];
    vad_pkg::t_side           stg_side [0:vad_pkg::NSTG];
    vad_pkg::t_root           fin_root;
    vad_pkg::t_side           fin_side;
    vad_pkg::t_vtx_out        n_out;

    // The pipeline moves unless a result waits at a stalled output.
    assign n_adv   = !(r_out_vld && i_stall);
    assign o_stall = !n_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_color  <= vad_pkg::DEFAULT_COLOR_RESET;
            r_alpha_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vad_pkg::CFG_DEFAULT_COLOR: r_def_color  <= i_cfg_data;
                vad_pkg::CFG_ALPHA_MODE:    r_alpha_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vad_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (n_adv),
        .i_valid      (i_valid),
        .i_vtx        (i_data),
        .i_def_color  (r_def_color),
        .i_alpha_mode (r_alpha_mode),
        .o_valid      (stg_vld[0]),
        .o_side       (stg_side[0]),
        .o_root       (stg_root[0])
    );

    // Root search, most significant result bit first.
    for (genvar g = 0; g < vad_pkg::NSTG; g++) begin : g_root
        vad_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (n_adv),
            .i_bit   (vad_pkg::BW'(vad_pkg::NSTG - 1 - g)),
            .i_valid (stg_vld[g]),
            .i_root  (stg_root[g]),
            .i_side  (stg_side[g]),
            .o_valid (stg_vld[g+1]),
            .o_root  (stg_root[g+1]),
            .o_side  (stg_side[g+1])
        );
    end

    assign fin_root = stg_root[vad_pkg::NSTG];
    assign fin_side = stg_side[vad_pkg::NSTG];

    // Apply signs, or the default normal when none was supplied.
    always_comb begin
        n_out.pos_x       = fin_side.pos_x;
        n_out.pos_y       = fin_side.pos_y;
        n_out.pos_z       = fin_side.pos_z;
        n_out.red         = fin_side.red;
        n_out.green       = fin_side.green;
        n_out.blue        = fin_side.blue;
        n_out.alpha       = fin_side.alpha;
        n_out.feature_out = fin_side.feature_out;
        if (fin_side.has_normal) begin
            n_out.norm_x = fin_side.neg[0] ? vad_pkg::NW'(16'd0 - {1'b0, fin_root.n[0]})
                                           : {1'b0, fin_root.n[0]};
            n_out.norm_y = fin_side.neg[1] ? vad_pkg::NW'(16'd0 - {1'b0, fin_root.n[1]})
                                           : {1'b0, fin_root.n[1]};
            n_out.norm_z = fin_side.neg[2] ? vad_pkg::NW'(16'd0 - {1'b0, fin_root.n[2]})
                                           : {1'b0, fin_root.n[2]};
        end else begin
            n_out.norm_x = '0;
            n_out.norm_y = '0;
            n_out.norm_z = vad_pkg::NORM_ONE;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_adv) begin
            r_out_vld <= stg_vld[vad_pkg::NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // The input stalls only while a result waits at a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // Normal components never exceed unit length.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_data.norm_x) <= 16384 && $signed(o_data.norm_x) >= -16384 &&
                     $signed(o_data.norm_y) <= 16384 && $signed(o_data.norm_y) >= -16384 &&
                     $signed(o_data.norm_z) <= 16384 && $signed(o_data.norm_z) >= -16384))
        else $error("normal component out of range");

    // Positions stay within 0..1 in Q1.16.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pos_x <= 17'd65536 && o_data.pos_y <= 17'd65536 &&
                     o_data.pos_z <= 17'd65536))
        else $error("position out of range");

endmodule
